[hw/rtl/dwpid_pkg.sv]
// Shared types, constants and the command scaling function of the wheel speed controller.
package dwpid_pkg;

   localparam int SPEED_W    = 13;
   localparam int CMD_W      = 9;
   localparam int TGT_W      = 10;
   localparam int ERR_W      = 14;
   localparam int DERR_W     = 15;
   localparam int INTEG_W    = 25;
   localparam int PWM_W      = 9;
   localparam int GAIN_W     = 16;
   localparam int CSR_ADDR_W = 2;

   // registers inside one control-law lane, input to output
   localparam int LAW_DEPTH = 7;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_PROP  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_INTEG = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_DERIV = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd256;
   localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd0;

   localparam logic signed [INTEG_W-1:0] INTEG_LIMIT  = 25'sd10000000;
   localparam logic signed [TGT_W-1:0]   TGT_DEADBAND = 10'sd10;

   // cmd * 500 / 255, reciprocal of 255 at 2^-24
   localparam logic [16:0] CMD_SCALE_NUM = 17'd500;
   localparam logic [16:0] CMD_SCALE_DEN = 17'd255;
   localparam logic [33:0] CMD_RECIP     = 34'd65793;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } gains_type;

   typedef struct packed {
      logic                       zero;
      logic signed [TGT_W-1:0]    target;
      logic signed [ERR_W-1:0]    err;
      logic signed [INTEG_W-1:0]  integ;
      logic signed [DERR_W-1:0]   derr;
   } wheel_terms_type;

   // trunc(c * 500 / 255); one correction step after the reciprocal multiply
   function automatic logic signed [TGT_W-1:0] scale_cmd(input logic signed [CMD_W-1:0] c);
      logic [CMD_W-1:0] mag;
      logic [16:0]      x;
      logic [33:0]      prod;
      logic [8:0]       q0;
      logic [16:0]      rem;
      logic [8:0]       q;
      mag  = c[CMD_W-1] ? CMD_W'(-c) : CMD_W'(c);
      x    = 17'(mag) * CMD_SCALE_NUM;
      prod = 34'(x) * CMD_RECIP;
      q0   = prod[32:24];
      rem  = x - 17'(q0) * CMD_SCALE_DEN;
      q    = (rem >= CMD_SCALE_DEN) ? q0 + 9'd1 : q0;
      return c[CMD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

endpackage

[hw/rtl/dwpid_state.sv]
// Per-wheel loop state: target, error integral and last error, updated once per word.
module dwpid_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                upd,
   input  logic                                cmd_valid,
   input  logic                                stop,
   input  logic signed [dwpid_pkg::TGT_W-1:0]  cmd_target,
   input  logic signed [dwpid_pkg::SPEED_W-1:0] speed,
   output dwpid_pkg::wheel_terms_type          terms
);
   import dwpid_pkg::*;

   logic signed [TGT_W-1:0]   target_ff, target_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   prev_ff, prev_in;

   logic signed [TGT_W-1:0]   tgt;
   logic                      dead;
   logic signed [ERR_W-1:0]   err;
   logic signed [INTEG_W:0]   sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [DERR_W-1:0]  derr;

   always_comb begin
      tgt  = cmd_valid ? cmd_target : target_ff;
      dead = (tgt > -TGT_DEADBAND) && (tgt < TGT_DEADBAND);
      err  = ERR_W'(tgt) - ERR_W'(speed);
      sum  = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(err);
      if (sum > INTEG_LIMIT) begin
         integ_sat = INTEG_LIMIT;
      end else if (sum < -INTEG_LIMIT) begin
         integ_sat = -INTEG_LIMIT;
      end else begin
         integ_sat = sum[INTEG_W-1:0];
      end
      derr = DERR_W'(err) - DERR_W'(prev_ff);

      priority if (stop) begin
         target_in = '0;
         integ_in  = '0;
         prev_in   = '0;
      end else if (dead) begin
         target_in = tgt;
         integ_in  = '0;
         prev_in   = '0;
      end else begin
         target_in = tgt;
         integ_in  = integ_sat;
         prev_in   = err;
      end

      terms.zero   = stop || dead;
      terms.target = tgt;
      terms.err    = err;
      terms.integ  = integ_sat;
      terms.derr   = derr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         integ_ff  <= '0;
         prev_ff   <= '0;
      end else if (upd) begin
         target_ff <= target_in;
         integ_ff  <= integ_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

[hw/rtl/dwpid_law.sv]
// Per-wheel control law pipeline: gain products, sum, scaling by 1/256000 and PWM clamp.
module dwpid_law (
   input  logic                               clock,
   input  logic                               en,
   input  dwpid_pkg::gains_type               gains,
   input  dwpid_pkg::wheel_terms_type         terms,
   output logic signed [dwpid_pkg::PWM_W-1:0] pwm
);
   import dwpid_pkg::*;

   localparam int PP_W   = 31;
   localparam int PI_W   = 41;
   localparam int PD_W   = 31;
   localparam int SA_W   = 36;
   localparam int ACC_W  = 44;
   localparam int SHR    = 11;              // 256000 = 2^11 * 125
   localparam int XS_W   = ACC_W - SHR;
   localparam int X_W    = 15;
   localparam int Q_W    = 8;
   localparam int RPROD_W = 30;
   localparam int RSHR   = 21;

   localparam logic signed [SA_W-1:0]  K_FF    = 36'sd102400;
   localparam logic signed [SA_W-1:0]  K_PROP  = 36'sd100;
   localparam logic signed [ACC_W-1:0] K_DERIV = 44'sd10000;
   localparam logic [XS_W-1:0]         SAT_X   = 33'd32000;   // quotient reaches 256
   localparam logic [RPROD_W-1:0]      DIV_RECIP = 30'd16777; // 2^21 / 125
   localparam logic [X_W-1:0]          DIV_K   = 15'd125;
   localparam logic [Q_W-1:0]          PWM_MAX = 8'd255;

   // stage 3: terms
   wheel_terms_type t3_ff;
   // stage 4: products
   logic signed [PP_W-1:0]  pp_ff, pp_in;
   logic signed [PI_W-1:0]  pi_ff, pi_in;
   logic signed [PD_W-1:0]  pd_ff, pd_in;
   logic signed [TGT_W-1:0] tgt4_ff;
   logic                    zero4_ff;
   // stage 5: partial sums
   logic signed [SA_W-1:0]  sa_ff, sa_in;
   logic signed [ACC_W-1:0] sb_ff, sb_in;
   logic                    zero5_ff;
   // stage 6: full sum
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    zero6_ff;
   // stage 7: magnitude / 2048
   logic [ACC_W-1:0]        mag;
   logic [XS_W-1:0]         xs;
   logic [X_W-1:0]          x7_ff, x7_in;
   logic                    sat7_ff, sat7_in, neg7_ff, zero7_ff;
   // stage 8: quotient estimate
   logic [RPROD_W-1:0]      rprod;
   logic [X_W-1:0]          x8_ff;
   logic [Q_W-1:0]          q0_ff, q0_in;
   logic                    sat8_ff, neg8_ff, zero8_ff;
   // stage 9: result
   logic [X_W-1:0]          rem;
   logic [Q_W-1:0]          q, qmag;
   logic signed [PWM_W-1:0] pwm_ff, pwm_in;

   always_comb begin
      pp_in = PP_W'($signed({1'b0, gains.prop}))  * PP_W'(t3_ff.err);
      pi_in = PI_W'($signed({1'b0, gains.integ})) * PI_W'(t3_ff.integ);
      pd_in = PD_W'($signed({1'b0, gains.deriv})) * PD_W'(t3_ff.derr);

      sa_in = SA_W'(tgt4_ff) * K_FF + SA_W'(pp_ff) * K_PROP;
      sb_in = ACC_W'(pi_ff) + ACC_W'(pd_ff) * K_DERIV;

      acc_in = ACC_W'(sa_ff) + sb_ff;

      mag     = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      xs      = mag[ACC_W-1:SHR];
      sat7_in = (xs >= SAT_X);
      x7_in   = sat7_in ? '0 : xs[X_W-1:0];

      rprod = RPROD_W'(x7_ff) * DIV_RECIP;
      q0_in = rprod[RSHR+Q_W-1:RSHR];

      // estimate is at most one low
      rem  = x8_ff - X_W'(q0_ff) * DIV_K;
      q    = (rem >= DIV_K) ? q0_ff + 8'd1 : q0_ff;
      qmag = sat8_ff ? PWM_MAX : q;
      priority if (zero8_ff) begin
         pwm_in = '0;
      end else if (neg8_ff) begin
         pwm_in = -$signed({1'b0, qmag});
      end else begin
         pwm_in = $signed({1'b0, qmag});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff    <= terms;
         pp_ff    <= pp_in;
         pi_ff    <= pi_in;
         pd_ff    <= pd_in;
         tgt4_ff  <= t3_ff.target;
         zero4_ff <= t3_ff.zero;
         sa_ff    <= sa_in;
         sb_ff    <= sb_in;
         zero5_ff <= zero4_ff;
         acc_ff   <= acc_in;
         zero6_ff <= zero5_ff;
         x7_ff    <= x7_in;
         sat7_ff  <= sat7_in;
         neg7_ff  <= acc_ff[ACC_W-1];
         zero7_ff <= zero6_ff;
         x8_ff    <= x7_ff;
         q0_ff    <= q0_in;
         sat8_ff  <= sat7_ff;
         neg8_ff  <= neg7_ff;
         zero8_ff <= zero7_ff;
         pwm_ff   <= pwm_in;
      end
   end

   assign pwm = pwm_ff;

endmodule

[hw/rtl/dual_wheel_pid_speed_control_top.sv]
// Top level of the dual-wheel PID speed controller with feedforward.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    speeds, command, safety flags
//   rsp      out        rsp_valid/stall    pwm left/right, safety_stopped, estop_raise
//   csr      in         csr_wr_en          csr_addr, csr_wr_data (gains)
//
// One word is accepted per cycle while no result is stalled at the output.
// The rate is set by the per-wheel state loop (target, integral, last error) in stage 2,
// which closes through its own registers alone; everything after it is a feed-forward pipeline.
// Reset (synchronous) empties the pipeline, clears the wheel state, restores the gains.
// A stalled result freezes the whole pipeline and holds req_stall in the same cycle.
module dual_wheel_pid_speed_control_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dwpid_pkg::SPEED_W-1:0]  req_speed_left,
   input  logic signed [dwpid_pkg::SPEED_W-1:0]  req_speed_right,
   input  logic                                  req_cmd_valid,
   input  logic signed [dwpid_pkg::CMD_W-1:0]    req_cmd_left,
   input  logic signed [dwpid_pkg::CMD_W-1:0]    req_cmd_right,
   input  logic                                  req_cmd_estop,
   input  logic                                  req_estop_event,
   input  logic                                  req_obstacle_event,
   input  logic                                  req_system_estop_state,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dwpid_pkg::PWM_W-1:0]    rsp_pwm_left,
   output logic signed [dwpid_pkg::PWM_W-1:0]    rsp_pwm_right,
   output logic                                  rsp_safety_stopped,
   output logic                                  rsp_estop_raise,
   input  logic                                  csr_wr_en,
   input  logic [dwpid_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [dwpid_pkg::GAIN_W-1:0]          csr_wr_data
);
   import dwpid_pkg::*;

   localparam int PIPE_DEPTH = LAW_DEPTH + 2;

   typedef struct packed {
      logic stop;
      logic raise;
   } flags_type;

   logic en;

   gains_type gains_ff, gains_in;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   flags_type             flg_ff [LAW_DEPTH+1];
   flags_type             flg_in;

   // stage 1: input word
   logic signed [SPEED_W-1:0] s1_speed_l_ff, s1_speed_r_ff;
   logic                      s1_cmd_valid_ff, s1_cmd_estop_ff;
   logic signed [CMD_W-1:0]   s1_cmd_l_ff, s1_cmd_r_ff;
   logic                      s1_estop_ff, s1_obstacle_ff, s1_sys_estop_ff;

   // stage 2: scaled command
   logic signed [SPEED_W-1:0] s2_speed_l_ff, s2_speed_r_ff;
   logic                      s2_cmd_valid_ff;
   logic signed [TGT_W-1:0]   s2_tgt_l_ff, s2_tgt_l_in, s2_tgt_r_ff, s2_tgt_r_in;

   wheel_terms_type terms_l, terms_r;
   logic            upd;

   assign en        = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !en;
   assign upd       = en && vld_ff[1];

   always_comb begin
      gains_in = gains_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_GAIN_PROP:  gains_in.prop  = csr_wr_data;
            CSR_GAIN_INTEG: gains_in.integ = csr_wr_data;
            CSR_GAIN_DERIV: gains_in.deriv = csr_wr_data;
            default:        gains_in = gains_ff;
         endcase
      end

      vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

      flg_in.raise = s1_cmd_valid_ff && s1_cmd_estop_ff;
      flg_in.stop  = flg_in.raise || s1_estop_ff || s1_obstacle_ff || s1_sys_estop_ff;

      s2_tgt_l_in = scale_cmd(s1_cmd_l_ff);
      s2_tgt_r_in = scale_cmd(s1_cmd_r_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= GAIN_PROP_RST;
         gains_ff.integ <= GAIN_INTEG_RST;
         gains_ff.deriv <= GAIN_DERIV_RST;
         vld_ff         <= '0;
      end else begin
         gains_ff <= gains_in;
         if (en) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_speed_l_ff   <= req_speed_left;
         s1_speed_r_ff   <= req_speed_right;
         s1_cmd_valid_ff <= req_cmd_valid;
         s1_cmd_l_ff     <= req_cmd_left;
         s1_cmd_r_ff     <= req_cmd_right;
         s1_cmd_estop_ff <= req_cmd_estop;
         s1_estop_ff     <= req_estop_event;
         s1_obstacle_ff  <= req_obstacle_event;
         s1_sys_estop_ff <= req_system_estop_state;

         s2_speed_l_ff   <= s1_speed_l_ff;
         s2_speed_r_ff   <= s1_speed_r_ff;
         s2_cmd_valid_ff <= s1_cmd_valid_ff;
         s2_tgt_l_ff     <= s2_tgt_l_in;
         s2_tgt_r_ff     <= s2_tgt_r_in;

         flg_ff[0] <= flg_in;
         for (int i = 1; i <= LAW_DEPTH; i++) begin
            flg_ff[i] <= flg_ff[i-1];
         end
      end
   end

   dwpid_state u_state_left (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .cmd_valid  (s2_cmd_valid_ff),
      .stop       (flg_ff[0].stop),
      .cmd_target (s2_tgt_l_ff),
      .speed      (s2_speed_l_ff),
      .terms      (terms_l)
   );

   dwpid_state u_state_right (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .cmd_valid  (s2_cmd_valid_ff),
      .stop       (flg_ff[0].stop),
      .cmd_target (s2_tgt_r_ff),
      .speed      (s2_speed_r_ff),
      .terms      (terms_r)
   );

   dwpid_law u_law_left (
      .clock (clock),
      .en    (en),
      .gains (gains_ff),
      .terms (terms_l),
      .pwm   (rsp_pwm_left)
   );

   dwpid_law u_law_right (
      .clock (clock),
      .en    (en),
      .gains (gains_ff),
      .terms (terms_r),
      .pwm   (rsp_pwm_right)
   );

   assign rsp_valid          = vld_ff[PIPE_DEPTH-1];
   assign rsp_safety_stopped = flg_ff[LAW_DEPTH].stop;
   assign rsp_estop_raise    = flg_ff[LAW_DEPTH].raise;

`ifndef SYNTH
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while result is stalled");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_safety_stopped) |-> (rsp_pwm_left == '0 && rsp_pwm_right == '0))
      else $error("nonzero drive on a safety stop word");

   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pwm_left != 9'sh100 && rsp_pwm_right != 9'sh100))
      else $error("drive value outside +-255");

   a_raise_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_estop_raise) |-> rsp_safety_stopped)
      else $error("estop request without safety stop");
`endif

endmodule
